FILE: hw/rtl/lpr_pkg.sv
// ============================================================================
// lpr_pkg
// Shared constants, command codes and controller/datapath link types for the
// longest-prefix route lookup block.
// ============================================================================
package lpr_pkg;

    // Field widths fixed by the transaction format
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 2;
    localparam int IDX_IN_W = 4;
    localparam int LEN_W    = 6;

    // Default table depth
    localparam int ENTRIES_DEF = 16;

    // Input transaction command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_wr;      // clear valid bit at sweep counter, advance counter
        logic tbl_wr;      // write route entry from input transaction
        logic scan_start;  // latch destination, restart counter and best match
        logic scan_rd;     // read entry at counter, advance counter
        logic out_load;    // load result register from best match
    } t_lpr_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic cnt_last;    // counter points at the last table entry
        logic out_free;    // result register can take a new result this cycle
    } t_lpr_sts;

endpackage : lpr_pkg

FILE: hw/rtl/longest_prefix_route_lookup.sv
// ============================================================================
// longest_prefix_route_lookup
// Route table with longest-prefix-match lookup.
// Write transaction: no result; the next transaction is taken the next cycle.
// Lookup: the table is scanned one entry per cycle, then the best match is loaded
//   into the result register; no new transaction is taken until it is loaded.
// Reset: synchronous; a clearing pass over all entries zeroes the valid bits,
//   with input stall held high until it ends.
// ============================================================================
module longest_prefix_route_lookup #(
    parameter int ENTRIES = lpr_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [lpr_pkg::IDX_IN_W-1:0]  i_entry_index,
    input  logic                          i_entry_valid,
    input  logic [lpr_pkg::ADDR_W-1:0]    i_route_prefix,
    input  logic [lpr_pkg::ADDR_W-1:0]    i_route_mask,
    input  logic [lpr_pkg::ADDR_W-1:0]    i_route_gateway,
    input  logic [lpr_pkg::PORT_W-1:0]    i_route_port,
    input  logic [lpr_pkg::ADDR_W-1:0]    i_lookup_address,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [lpr_pkg::ADDR_W-1:0]    o_next_hop,
    output logic [lpr_pkg::PORT_W-1:0]    o_out_port,
    output logic [lpr_pkg::IDX_IN_W-1:0]  o_matched_index,
    output logic [lpr_pkg::LEN_W-1:0]     o_prefix_length
);
    import lpr_pkg::*;

    t_lpr_cmd cmd;
    t_lpr_sts sts;

    // Sequencer
    lpr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_stall   (o_stall),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    // Table, compare and result register
    lpr_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_entry_index    (i_entry_index),
        .i_entry_valid    (i_entry_valid),
        .i_route_prefix   (i_route_prefix),
        .i_route_mask     (i_route_mask),
        .i_route_gateway  (i_route_gateway),
        .i_route_port     (i_route_port),
        .i_lookup_address (i_lookup_address),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_found          (o_found),
        .o_next_hop       (o_next_hop),
        .o_out_port       (o_out_port),
        .o_matched_index  (o_matched_index),
        .o_prefix_length  (o_prefix_length)
    );

endmodule : longest_prefix_route_lookup

FILE: hw/rtl/lpr_dp.sv
// ============================================================================
// lpr_dp
// Route table storage, sweep/scan counter, match compare with best-entry
// tracking, and the result register.
// ============================================================================
module lpr_dp #(
    parameter int ENTRIES = lpr_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpr_pkg::t_lpr_cmd             i_cmd,
    output lpr_pkg::t_lpr_sts             o_sts,
    input  logic [lpr_pkg::IDX_IN_W-1:0]  i_entry_index,
    input  logic                          i_entry_valid,
    input  logic [lpr_pkg::ADDR_W-1:0]    i_route_prefix,
    input  logic [lpr_pkg::ADDR_W-1:0]    i_route_mask,
    input  logic [lpr_pkg::ADDR_W-1:0]    i_route_gateway,
    input  logic [lpr_pkg::PORT_W-1:0]    i_route_port,
    input  logic [lpr_pkg::ADDR_W-1:0]    i_lookup_address,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [lpr_pkg::ADDR_W-1:0]    o_next_hop,
    output logic [lpr_pkg::PORT_W-1:0]    o_out_port,
    output logic [lpr_pkg::IDX_IN_W-1:0]  o_matched_index,
    output logic [lpr_pkg::LEN_W-1:0]     o_prefix_length
);
    import lpr_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Length of the leading run of ones: bit k of run is set when mask
    // bits k..31 are all ones, so the popcount of run is the run length.
    function automatic logic [LEN_W-1:0] lead_ones(input logic [ADDR_W-1:0] m);
        logic [ADDR_W-1:0] run;
        for (int k = 0; k < ADDR_W; k++) begin
            run[k] = &(m | ~({ADDR_W{1'b1}} << k));
        end
        return LEN_W'($countones(run));
    endfunction

    // Table memories
    logic [ADDR_W-1:0] r_pfx_mem  [ENTRIES];
    logic [ADDR_W-1:0] r_msk_mem  [ENTRIES];
    logic [ADDR_W-1:0] r_gw_mem   [ENTRIES];
    logic [PORT_W-1:0] r_port_mem [ENTRIES];
    logic [LEN_W-1:0]  r_len_mem  [ENTRIES];
    logic              r_vld_mem  [ENTRIES];

    logic [IDX_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  wr_addr;
    logic              wr_in_range;
    logic              tbl_we;

    // Registered read stage
    logic              r_rd_pipe;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_rd_vld;
    logic [ADDR_W-1:0] r_rd_pfx;
    logic [ADDR_W-1:0] r_rd_msk;
    logic [ADDR_W-1:0] r_rd_gw;
    logic [PORT_W-1:0] r_rd_port;
    logic [LEN_W-1:0]  r_rd_len;

    // Best match so far
    logic [ADDR_W-1:0] r_dest;
    logic              r_best_hit;
    logic [LEN_W-1:0]  r_best_len;
    logic [IDX_W-1:0]  r_best_idx;
    logic [ADDR_W-1:0] r_best_gw;
    logic [PORT_W-1:0] r_best_port;
    logic              cand_match;
    logic              cand_take;

    logic              r_out_vld;

    // Write port address: sweep counter while clearing, else the slot index
    assign wr_in_range = (32'(i_entry_index) < 32'(ENTRIES));
    assign tbl_we      = i_cmd.tbl_wr && wr_in_range;
    assign wr_addr     = i_cmd.clr_wr ? r_cnt : IDX_W'(i_entry_index);

    // Entry payload stores, no reset
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_pfx_mem[wr_addr]  <= i_route_prefix;
            r_msk_mem[wr_addr]  <= i_route_mask;
            r_gw_mem[wr_addr]   <= i_route_gateway;
            r_port_mem[wr_addr] <= i_route_port;
            r_len_mem[wr_addr]  <= lead_ones(i_route_mask);
        end
    end

    // Valid store, swept to zero after reset
    always_ff @(posedge i_clk) begin
        if (tbl_we || i_cmd.clr_wr) begin
            r_vld_mem[wr_addr] <= tbl_we ? i_entry_valid : 1'b0;
        end
    end

    // Sweep / scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.scan_start) begin
            r_cnt <= '0;
        end else if (i_cmd.scan_rd || i_cmd.clr_wr) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pipe <= 1'b0;
        end else begin
            r_rd_pipe <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_rd_idx  <= r_cnt;
            r_rd_vld  <= r_vld_mem[r_cnt];
            r_rd_pfx  <= r_pfx_mem[r_cnt];
            r_rd_msk  <= r_msk_mem[r_cnt];
            r_rd_gw   <= r_gw_mem[r_cnt];
            r_rd_port <= r_port_mem[r_cnt];
            r_rd_len  <= r_len_mem[r_cnt];
        end
    end

    // Match compare; strictly longer wins so the lowest index keeps ties
    assign cand_match = r_rd_pipe && r_rd_vld && (((r_dest ^ r_rd_pfx) & r_rd_msk) == '0);
    assign cand_take  = cand_match && (!r_best_hit || (r_rd_len > r_best_len));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_hit <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_best_hit <= 1'b0;
        end else if (cand_take) begin
            r_best_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_dest <= i_lookup_address;
        end
        if (cand_take) begin
            r_best_len  <= r_rd_len;
            r_best_idx  <= r_rd_idx;
            r_best_gw   <= r_rd_gw;
            r_best_port <= r_rd_port;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_found         <= r_best_hit;
            o_next_hop      <= r_best_hit ? r_best_gw : '0;
            o_out_port      <= r_best_hit ? r_best_port : '0;
            o_matched_index <= r_best_hit ? IDX_IN_W'(r_best_idx) : '0;
            o_prefix_length <= r_best_hit ? r_best_len : '0;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_sts.out_free = !r_out_vld || !i_stall;
    assign o_sts.cnt_last = (r_cnt == IDX_W'(ENTRIES - 1));

`ifndef SYNTHESIS
    // A miss reports all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_found) |-> (o_next_hop == '0 && o_out_port == '0 &&
            o_matched_index == '0 && o_prefix_length == '0))
        else $error("miss result carries nonzero fields");

    // Prefix length never exceeds the address width
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (o_prefix_length <= LEN_W'(ADDR_W)))
        else $error("prefix length out of range");

    // Read stage only holds data fetched by a scan read
    a_rd_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pipe |-> $past(i_cmd.scan_rd))
        else $error("read stage valid without scan read");
`endif

endmodule : lpr_dp

FILE: hw/rtl/lpr_ctrl.sv
// ============================================================================
// lpr_ctrl
// Sequencer: clearing sweep after reset, transaction intake, table scan,
// and result hand-off to the result register.
// ============================================================================
module lpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_command,
    output logic              o_stall,
    output lpr_pkg::t_lpr_cmd o_cmd,
    input  lpr_pkg::t_lpr_sts i_sts
);
    import lpr_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_FLUSH = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_command == CMD_LOOKUP) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end else begin
                        o_cmd.tbl_wr = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // last entry is compared this cycle
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // Never overwrite a result still waiting downstream
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded while output busy");

    // Scan ends after the last entry read
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.cnt_last) |=> (r_state == S_FLUSH))
        else $error("scan did not end on last entry");

    // Clearing sweep never overlaps table writes or reads
    a_clr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr_wr |-> !(o_cmd.tbl_wr || o_cmd.scan_rd || o_cmd.scan_start))
        else $error("clear overlaps table access");
`endif

endmodule : lpr_ctrl
